/* hdl/bmp_rle_palette_decoder_defines.svh */
// Assertion macros for the BMP RLE palette decoder sources.
`ifndef BMP_RLE_PALETTE_DECODER_DEFINES_SVH
`define BMP_RLE_PALETTE_DECODER_DEFINES_SVH

`ifndef ASSERT_OFF

// Same-cycle implication: ante |-> cons
`define BMPRLE_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication: ante |=> cons
`define BMPRLE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define BMPRLE_ASSERT_IMPL(label, clk, rst, ante, cons, msg)

`define BMPRLE_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

/* hdl/bmprle_pkg.sv */
// Types, codes and defaults for the BMP RLE palette decoder.
package bmprle_pkg;

   localparam int DEF_COORD_BITS    = 16;
   localparam int DEF_PALETTE_DEPTH = 256;

   localparam logic [3:0] NIBBLE_MASK = 4'hf;

   // command codes
   localparam logic [1:0] CMD_BYTE    = 2'd0;
   localparam logic [1:0] CMD_PAL     = 2'd1;
   localparam logic [1:0] CMD_RESTART = 2'd2;

   // result kinds
   localparam logic [1:0] KIND_SPAN = 2'd0;
   localparam logic [1:0] KIND_DONE = 2'd1;
   localparam logic [1:0] KIND_ERR  = 2'd2;

   // escape second bytes
   localparam logic [7:0] ESC_EOL   = 8'd0;
   localparam logic [7:0] ESC_EOB   = 8'd1;
   localparam logic [7:0] ESC_DELTA = 8'd2;

   // register indexes
   localparam int CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FOUR_BIT_MODE = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_WIDTH   = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_HEIGHT  = 2'd2;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] data_byte;
      logic       stream_end;
      logic [7:0] pal_index;
      logic [7:0] pal_red;
      logic [7:0] pal_green;
      logic [7:0] pal_blue;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] x_start;
      logic [15:0] row;
      logic [7:0]  span_len;
      logic [7:0]  red_a;
      logic [7:0]  green_a;
      logic [7:0]  blue_a;
      logic [7:0]  red_b;
      logic [7:0]  green_b;
      logic [7:0]  blue_b;
   } rsp_type;

   // palette write request
   typedef struct packed {
      logic        en;
      logic [7:0]  index;
      logic [23:0] rgb;
   } pal_wr_type;

   // palette read request, two ports
   typedef struct packed {
      logic       en;
      logic [7:0] index_a;
      logic [7:0] index_b;
   } pal_rd_type;

endpackage

/* hdl/bmprle_palette.sv */
// Palette memory: one write port, two registered read ports, black beyond depth.
module bmprle_palette
   import bmprle_pkg::*;
#(
   parameter int PALETTE_DEPTH = DEF_PALETTE_DEPTH
) (
   input  logic        clock,
   input  pal_wr_type  wr,
   input  pal_rd_type  rd,
   output logic [23:0] rd_data_a,
   output logic [23:0] rd_data_b
);

   localparam int         PAL_AW    = $clog2(PALETTE_DEPTH);
   localparam logic [8:0] DEPTH_LIM = 9'(PALETTE_DEPTH);

   logic [23:0] mem_ff [PALETTE_DEPTH];
   logic [23:0] rd_a_ff;
   logic [23:0] rd_b_ff;
   logic        hit_a_ff;
   logic        hit_b_ff;

   logic wr_hit;
   logic rd_hit_a;
   logic rd_hit_b;

   assign wr_hit   = {1'b0, wr.index}   < DEPTH_LIM;
   assign rd_hit_a = {1'b0, rd.index_a} < DEPTH_LIM;
   assign rd_hit_b = {1'b0, rd.index_b} < DEPTH_LIM;

   always_ff @(posedge clock) begin
      if (wr.en && wr_hit) begin
         mem_ff[wr.index[PAL_AW-1:0]] <= wr.rgb;
      end
   end

   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_a_ff  <= mem_ff[rd.index_a[PAL_AW-1:0]];
         rd_b_ff  <= mem_ff[rd.index_b[PAL_AW-1:0]];
         hit_a_ff <= rd_hit_a;
         hit_b_ff <= rd_hit_b;
      end
   end

   assign rd_data_a = hit_a_ff ? rd_a_ff : '0;
   assign rd_data_b = hit_b_ff ? rd_b_ff : '0;

endmodule

/* hdl/bmp_rle_palette_decoder.sv */
// Top level of the BMP RLE8/RLE4 decoder with palette expansion.
//
//   channel  ports                              direction  handshake
//   ------   ---------------------------------  ---------  ------------------------
//   request  req_valid req_stall req_payload    in         valid & !stall
//   result   rsp_valid rsp_stall rsp_payload    out        valid & !stall
//   config   csr_valid csr_ready csr_index/data in         valid & ready (ready = 1)
//
// One request transaction per cycle sustained while rsp_stall is low; a result passes through
// the input/palette-read register, then the result register.
// The palette read is started on the request edge so the decode stage sees registered data.
// Synchronous active-high reset clears control state; palette contents stay undefined.
// rsp_stall holds the result register and backs up into req_stall only when the
// input register is also occupied.
`include "bmp_rle_palette_decoder_defines.svh"

module bmp_rle_palette_decoder
   import bmprle_pkg::*;
#(
   parameter int COORD_BITS    = DEF_COORD_BITS,
   parameter int PALETTE_DEPTH = DEF_PALETTE_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_type                   req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_type                   rsp_payload,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [15:0]               csr_data
);

   localparam int CW = COORD_BITS;
   // compare width: holds coord + 255 and the 16-bit image size
   localparam int XW = (COORD_BITS >= 16) ? COORD_BITS + 1 : 17;

   typedef enum logic [4:0] {
      PH_FIRST  = 5'b00001,
      PH_SECOND = 5'b00010,
      PH_DX     = 5'b00100,
      PH_DY     = 5'b01000,
      PH_ABS    = 5'b10000
   } phase_type;

   typedef enum logic [2:0] {
      ST_RUN  = 3'b001,
      ST_DONE = 3'b010,
      ST_ERR  = 3'b100
   } status_type;

   // ---------------- configuration registers ----------------
   logic        mode_ff;
   logic [15:0] width_ff;
   logic [15:0] height_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= 1'b0;
         width_ff  <= '0;
         height_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FOUR_BIT_MODE: mode_ff   <= csr_data[0];
            CSR_IMAGE_WIDTH:   width_ff  <= csr_data;
            CSR_IMAGE_HEIGHT:  height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // ---------------- stage 1: input register + palette access ----------------
   logic       s1_valid_ff;
   logic       s1_valid_in;
   req_type    s1_item_ff;
   logic       req_accept;
   logic       s2_fire;
   pal_wr_type pal_wr;
   pal_rd_type pal_rd;
   logic [23:0] pal_a;
   logic [23:0] pal_b;

   assign s2_fire    = s1_valid_ff && (!rsp_valid || !rsp_stall);
   assign req_stall  = s1_valid_ff && !s2_fire;
   assign req_accept = req_valid && !req_stall;

   // palette writes land on the request edge; a later byte reads on a later edge
   assign pal_wr.en    = req_accept && (req_payload.cmd == CMD_PAL);
   assign pal_wr.index = req_payload.pal_index;
   assign pal_wr.rgb   = {req_payload.pal_red, req_payload.pal_green, req_payload.pal_blue};

   // port a: full byte (RLE8) or high nibble (RLE4); port b: low nibble
   assign pal_rd.en      = req_accept && (req_payload.cmd == CMD_BYTE);
   assign pal_rd.index_a = mode_ff ? {4'd0, req_payload.data_byte[7:4]}
                                   : req_payload.data_byte;
   assign pal_rd.index_b = {4'd0, req_payload.data_byte[3:0] & NIBBLE_MASK};

   bmprle_palette #(
      .PALETTE_DEPTH(PALETTE_DEPTH)
   ) u_palette (
      .clock     (clock),
      .wr        (pal_wr),
      .rd        (pal_rd),
      .rd_data_a (pal_a),
      .rd_data_b (pal_b)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s2_fire) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_item_ff <= req_payload;
      end
   end

   // ---------------- stage 2: parser state ----------------
   phase_type      phase_ff,    phase_in;
   logic [7:0]     held_ff,     held_in;
   logic [CW-1:0]  col_ff,      col_in;
   logic [CW-1:0]  row_ff,      row_in;
   logic [7:0]     abs_left_ff, abs_left_in;
   logic           abs_pos_ff,  abs_pos_in;
   logic [7:0]     dcol_ff,     dcol_in;
   status_type     status_ff,   status_in;

   logic [7:0]    b;
   logic [XW-1:0] col_x;
   logic [XW-1:0] row_x;
   logic [XW-1:0] width_x;
   logic [XW-1:0] height_x;
   logic [XW-1:0] rem;
   logic [7:0]    clip_cnt;
   logic [7:0]    clip_n;
   logic [7:0]    abs_k;
   logic [7:0]    step;
   logic [XW-1:0] col_sum;
   logic [CW-1:0] col_step;
   logic [CW-1:0] row_inc;
   logic          row_inc_done;
   logic [XW-1:0] nc;
   logic [XW-1:0] nr;
   logic          delta_bad;
   logic          row_end;
   logic [23:0]   color_b;

   assign b        = s1_item_ff.data_byte;
   assign col_x    = XW'(col_ff);
   assign row_x    = XW'(row_ff);
   assign width_x  = XW'(width_ff);
   assign height_x = XW'(height_ff);

   // room left on the row, and the clipped run length
   assign rem      = (col_x < width_x) ? (width_x - col_x) : '0;
   assign clip_cnt = (held_ff != 8'd0) ? held_ff : b;
   assign clip_n   = (XW'(clip_cnt) < rem) ? clip_cnt : rem[7:0];

   // absolute mode: two pixels per byte in RLE4 while two remain
   assign abs_k = (mode_ff && (abs_left_ff >= 8'd2)) ? 8'd2 : 8'd1;
   assign step  = (phase_ff == PH_ABS) ? abs_k : clip_n;

   assign col_sum  = col_x + XW'(step);
   assign col_step = col_sum[CW-1:0];

   assign row_inc      = row_ff + CW'(1);
   assign row_inc_done = XW'(row_inc) >= height_x;

   assign nc        = col_x + XW'(dcol_ff);
   assign nr        = row_x + XW'(b);
   assign delta_bad = (nc >= width_x) || (nr >= height_x);

   assign row_end = row_x >= height_x;

   // odd pixels: second nibble in RLE4 (black for a lone pixel), same color in RLE8
   assign color_b = mode_ff ? ((step > 8'd1) ? pal_b : 24'd0) : pal_a;

   logic    span;
   logic    res_valid;
   rsp_type res;

   always_comb begin
      phase_in    = phase_ff;
      held_in     = held_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      abs_left_in = abs_left_ff;
      abs_pos_in  = abs_pos_ff;
      dcol_in     = dcol_ff;
      status_in   = status_ff;
      span        = 1'b0;
      res_valid   = 1'b0;
      res         = '0;

      if (s2_fire) begin
         case (s1_item_ff.cmd)
            CMD_RESTART: begin
               phase_in    = PH_FIRST;
               held_in     = '0;
               col_in      = '0;
               row_in      = '0;
               abs_left_in = '0;
               abs_pos_in  = 1'b0;
               dcol_in     = '0;
               status_in   = ST_RUN;
            end
            CMD_BYTE: begin
               if (status_ff == ST_RUN) begin
                  if (row_end) begin
                     // nothing left to draw: byte not consumed
                     status_in = ST_DONE;
                  end else begin
                     case (phase_ff)
                        PH_FIRST: begin
                           held_in  = b;
                           phase_in = PH_SECOND;
                        end
                        PH_SECOND: begin
                           phase_in = PH_FIRST;
                           if (held_ff != 8'd0) begin
                              // encoded run
                              if (clip_n != 8'd0) begin
                                 span   = 1'b1;
                                 col_in = col_step;
                              end
                           end else if (b == ESC_EOL) begin
                              col_in = '0;
                              row_in = row_inc;
                              if (row_inc_done) begin
                                 status_in = ST_DONE;
                              end
                           end else if (b == ESC_EOB) begin
                              status_in = ST_DONE;
                           end else if (b == ESC_DELTA) begin
                              phase_in = PH_DX;
                           end else if (clip_n != 8'd0) begin
                              // absolute run; clipped to zero consumes nothing
                              abs_left_in = clip_n;
                              abs_pos_in  = 1'b0;
                              phase_in    = PH_ABS;
                           end
                        end
                        PH_DX: begin
                           dcol_in  = b;
                           phase_in = PH_DY;
                        end
                        PH_DY: begin
                           phase_in = PH_FIRST;
                           if (delta_bad) begin
                              status_in = ST_ERR;
                           end else begin
                              col_in = nc[CW-1:0];
                              row_in = nr[CW-1:0];
                           end
                        end
                        PH_ABS: begin
                           if (abs_left_ff != 8'd0) begin
                              span        = 1'b1;
                              col_in      = col_step;
                              abs_left_in = abs_left_ff - abs_k;
                           end
                           // byte parity tracks the pad to an even count
                           abs_pos_in = ~abs_pos_ff;
                           if ((abs_left_in == 8'd0) && !abs_pos_in) begin
                              phase_in = PH_FIRST;
                           end
                        end
                        default: begin
                           phase_in = PH_FIRST;
                        end
                     endcase

                     // truncated stream overrides any span from this byte
                     if ((status_in == ST_RUN) && s1_item_ff.stream_end) begin
                        status_in = ST_ERR;
                     end
                  end

                  res_valid = (status_in != ST_RUN) || span;
                  if (status_in == ST_DONE) begin
                     res.kind = KIND_DONE;
                  end else if (status_in == ST_ERR) begin
                     res.kind = KIND_ERR;
                  end else begin
                     res.kind     = KIND_SPAN;
                     res.x_start  = col_x[15:0];
                     res.row      = row_x[15:0];
                     res.span_len = step;
                     res.red_a    = pal_a[23:16];
                     res.green_a  = pal_a[15:8];
                     res.blue_a   = pal_a[7:0];
                     res.red_b    = color_b[23:16];
                     res.green_b  = color_b[15:8];
                     res.blue_b   = color_b[7:0];
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_FIRST;
         held_ff     <= '0;
         col_ff      <= '0;
         row_ff      <= '0;
         abs_left_ff <= '0;
         abs_pos_ff  <= 1'b0;
         dcol_ff     <= '0;
         status_ff   <= ST_RUN;
      end else begin
         phase_ff    <= phase_in;
         held_ff     <= held_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         abs_left_ff <= abs_left_in;
         abs_pos_ff  <= abs_pos_in;
         dcol_ff     <= dcol_in;
         status_ff   <= status_in;
      end
   end

   // ---------------- result register ----------------
   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   rsp_type rsp_payload_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s2_fire && res_valid) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_fire && res_valid) begin
         rsp_payload_ff <= res;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // ---------------- assertions ----------------
   `BMPRLE_ASSERT_IMPL(a_span_len_nonzero, clock, reset,
      rsp_valid && (rsp_payload.kind == KIND_SPAN), rsp_payload.span_len != 8'd0,
      "span result with zero length")

   `BMPRLE_ASSERT_IMPL(a_end_fields_clear, clock, reset,
      rsp_valid && (rsp_payload.kind != KIND_SPAN),
      (rsp_payload.x_start == 16'd0) && (rsp_payload.span_len == 8'd0) && (rsp_payload.red_a == 8'd0),
      "complete or error result carries span data")

   `BMPRLE_ASSERT_NEXT(a_end_sticky, clock, reset,
      s2_fire && res_valid && (res.kind != KIND_SPAN), status_ff != ST_RUN,
      "decoder still running after complete or error result")

   `BMPRLE_ASSERT_IMPL(a_abs_progress, clock, reset,
      phase_ff == PH_ABS, (abs_left_ff != 8'd0) || abs_pos_ff,
      "absolute phase with no pixels and no pad byte pending")

endmodule
